>>> sv/imhpq_pkg.sv
// shared types and constants of the indexed min-heap priority queue
`timescale 1ns / 1ps
`default_nettype none
package imhpq_pkg;
	localparam int CAP_W = 10;
	localparam int CAPACITY = 1 << CAP_W;
	localparam int HANDLE_W = 10;
	localparam int HANDLE_COUNT = 1 << HANDLE_W;
	localparam int KEY_W = 32;
	localparam int CNT_W = CAP_W + 1;
	localparam int QDEPTH = 2;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_EXTRACT = 2'd1;
	localparam logic [1:0] REQ_DECREASE = 2'd2;

	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_MIN = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;
	localparam logic [2:0] ST_DUP = 3'd5;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [KEY_W-1:0] key;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic signed [KEY_W-1:0] min_key;
		logic [HANDLE_W-1:0] min_handle;
	} rsp_t;
endpackage
`default_nettype wire

>>> sv/imhpq_front.sv
// front end: request intake and a short request queue
`timescale 1ns / 1ps
`default_nettype none
module imhpq_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire imhpq_pkg::req_t in_req,
	output logic q_valid,
	input wire logic q_ready,
	output imhpq_pkg::req_t q_req
);
	imhpq_pkg::req_t buf_q [imhpq_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'(imhpq_pkg::QDEPTH);
	assign q_valid = cnt_q != 2'd0;
	assign q_req = buf_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

>>> sv/imhpq_back.sv
// back end: heap memories and the sift sequencer
`timescale 1ns / 1ps
`default_nettype none
module imhpq_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire imhpq_pkg::req_t q_req,
	output logic out_valid,
	input wire logic out_ready,
	output imhpq_pkg::rsp_t out_rsp
);
	localparam int AW = imhpq_pkg::CAP_W;
	localparam int HW = imhpq_pkg::HANDLE_W;
	localparam int KW = imhpq_pkg::KEY_W;

	typedef enum logic [10:0] {
		S_CLR = 11'b00000000001,
		S_IDLE = 11'b00000000010,
		S_CHK = 11'b00000000100,
		S_DEC = 11'b00000001000,
		S_EXLAST = 11'b00000010000,
		S_UPRD = 11'b00000100000,
		S_UPCMP = 11'b00001000000,
		S_DNL = 11'b00010000000,
		S_DNR = 11'b00100000000,
		S_DNDEC = 11'b01000000000,
		S_OUT = 11'b10000000000
	} state_t;

	state_t state_q;
	// heap entry memory: key and handle together
	logic [KW+HW-1:0] heap_mem [imhpq_pkg::CAPACITY];
	// handle map entry: queued flag above the slot
	logic [AW:0] map_mem [imhpq_pkg::HANDLE_COUNT];
	logic [imhpq_pkg::CNT_W-1:0] count_q;
	logic [HW-1:0] clr_q;

	logic [AW-1:0] ra;
	logic [KW+HW-1:0] rd_q;
	logic [AW:0] map_rd_q;
	logic hwe;
	logic [AW-1:0] hwa;
	logic [KW+HW-1:0] hwd;
	logic mwe;
	logic [HW-1:0] mwa;
	logic [AW:0] mwd;

	imhpq_pkg::req_t req_q;
	logic signed [KW-1:0] cur_key_q;
	logic [HW-1:0] cur_h_q;
	logic [AW-1:0] pos_q;
	logic signed [KW-1:0] best_key_q;
	logic [HW-1:0] best_h_q;
	logic [AW-1:0] best_pos_q;
	logic have_best_q;
	imhpq_pkg::rsp_t rsp_q;

	logic signed [KW-1:0] rd_key;
	logic [HW-1:0] rd_h;
	logic map_queued;
	logic [AW-1:0] map_slot;
	logic [AW-1:0] parent;
	logic [AW:0] lchild;
	logic [AW:0] rchild;
	logic up_move;
	logic take_r;

	always_ff @(posedge clk) begin
		if (hwe) heap_mem[hwa] <= hwd;
		rd_q <= heap_mem[ra];
	end
	always_ff @(posedge clk) begin
		if (mwe) map_mem[mwa] <= mwd;
		map_rd_q <= map_mem[q_req.handle];
	end

	assign rd_key = rd_q[KW+HW-1:HW];
	assign rd_h = rd_q[HW-1:0];
	assign map_queued = map_rd_q[AW];
	assign map_slot = map_rd_q[AW-1:0];
	assign parent = (pos_q - AW'(1)) >> 1;
	assign lchild = {pos_q, 1'b1};
	assign rchild = lchild + (AW+1)'(1);
	assign up_move = pos_q != '0 && cur_key_q < rd_key;
	// right child wins only when strictly smaller than the left one and the entry
	assign take_r = rchild < count_q && rd_key < (have_best_q ? best_key_q : cur_key_q);

	assign q_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign out_rsp = rsp_q;

	always_comb begin
		ra = '0;
		hwe = 1'b0;
		hwa = pos_q;
		hwd = {cur_key_q, cur_h_q};
		mwe = 1'b0;
		mwa = cur_h_q;
		mwd = {1'b1, pos_q};
		case (state_q)
			S_CLR: begin
				mwe = 1'b1;
				mwa = clr_q;
				mwd = '0;
			end
			S_CHK: begin
				if (req_q.req_type == imhpq_pkg::REQ_EXTRACT) begin
					ra = AW'(count_q - 1'b1);
					// root handle leaves the queue
					if (count_q != '0) begin
						mwe = 1'b1;
						mwa = rd_h;
						mwd = '0;
					end
				end else ra = map_slot;
			end
			S_UPRD: ra = parent;
			S_UPCMP: begin
				hwe = 1'b1;
				mwe = 1'b1;
				if (up_move) begin
					hwd = rd_q;
					mwa = rd_h;
				end
			end
			S_DNL: ra = lchild[AW-1:0];
			S_DNR: ra = rchild[AW-1:0];
			S_DNDEC: begin
				hwe = 1'b1;
				mwe = 1'b1;
				if (take_r) begin
					hwd = rd_q;
					mwa = rd_h;
				end else if (have_best_q) begin
					hwd = {best_key_q, best_h_q};
					mwa = best_h_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: req_q <= q_req;
			S_CHK: begin
				cur_key_q <= req_q.key;
				cur_h_q <= req_q.handle;
				if (req_q.req_type == imhpq_pkg::REQ_PUSH) pos_q <= AW'(count_q);
				else pos_q <= map_slot;
			end
			// the moved last entry becomes the sifting entry
			S_EXLAST: begin
				cur_key_q <= rd_key;
				cur_h_q <= rd_h;
				pos_q <= '0;
			end
			S_UPCMP: if (up_move) pos_q <= parent;
			S_DNR: begin
				if (lchild < count_q && rd_key < cur_key_q) begin
					best_key_q <= rd_key;
					best_h_q <= rd_h;
					best_pos_q <= lchild[AW-1:0];
					have_best_q <= 1'b1;
				end else have_best_q <= 1'b0;
			end
			S_DNDEC: begin
				if (take_r) pos_q <= rchild[AW-1:0];
				else if (have_best_q) pos_q <= best_pos_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			count_q <= '0;
			clr_q <= '0;
			rsp_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						rsp_q <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= S_OUT;
					case (req_q.req_type)
						imhpq_pkg::REQ_PUSH: begin
							if (map_queued) rsp_q.status <= imhpq_pkg::ST_DUP;
							else if (count_q >= (imhpq_pkg::CNT_W)'(imhpq_pkg::CAPACITY))
								rsp_q.status <= imhpq_pkg::ST_FULL;
							else begin
								count_q <= count_q + 1'b1;
								state_q <= S_UPRD;
							end
						end
						imhpq_pkg::REQ_EXTRACT: begin
							if (count_q == '0) rsp_q.status <= imhpq_pkg::ST_EMPTY;
							else begin
								// root data is in rd_q now
								rsp_q.status <= imhpq_pkg::ST_MIN;
								rsp_q.min_key <= rd_key;
								rsp_q.min_handle <= rd_h;
								count_q <= count_q - 1'b1;
								state_q <= S_EXLAST;
							end
						end
						imhpq_pkg::REQ_DECREASE: begin
							if (!map_queued) rsp_q.status <= imhpq_pkg::ST_REJECT;
							else state_q <= S_DEC;
						end
						default: ;
					endcase
				end
				S_DEC: begin
					if (!(req_q.key < rd_key)) begin
						rsp_q.status <= imhpq_pkg::ST_REJECT;
						state_q <= S_OUT;
					end else state_q <= S_UPRD;
				end
				// nothing to sift when the heap just became empty
				S_EXLAST: state_q <= (count_q == '0) ? S_OUT : S_DNL;
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: state_q <= up_move ? S_UPRD : S_OUT;
				S_DNL: state_q <= S_DNR;
				S_DNR: state_q <= S_DNDEC;
				S_DNDEC: state_q <= (take_r || have_best_q) ? S_DNL : S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/indexed_min_heap_priority_queue.sv
// top level of the indexed min-heap priority queue
// usage:
//  s_axis carries requests: tuser = req_type, tdata = key then handle
//  m_axis returns one response per request: tdata = status, min_key,
//  min_handle from the lowest bit up
//  requests go through a two-entry queue into the heap sequencer
//  the sequencer reads the handle map as it takes a request, then checks it
//  push and decrease walk up the heap, a read and a compare step per level
//  extract walks down, per level: read left child, read right child, decide
//  a request takes longer the farther it sifts (rejects fastest, an
//  extract that sifts down to a leaf slowest); the sequencer takes
//  one request at a time
//  while m_axis_tready is low the response is held and the sequencer
//  waits; the queue takes two more requests, then s_axis_tready drops
//  after reset a pass over every handle clears the handle map and queued flags;
//  requests wait in the queue meanwhile; heap slots need no clearing
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_priority_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [47:0] s_axis_tdata, // key, handle
	input wire logic [1:0] s_axis_tuser, // req_type
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [47:0] m_axis_tdata // status, min_key, min_handle
);
	imhpq_pkg::req_t in_req, q_req;
	imhpq_pkg::rsp_t rsp;
	logic q_valid, q_ready;

	assign in_req.req_type = s_axis_tuser;
	assign in_req.key = s_axis_tdata[31:0];
	assign in_req.handle = s_axis_tdata[41:32];
	assign m_axis_tdata = {3'd0, rsp.min_handle, rsp.min_key, rsp.status};

	imhpq_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);
	imhpq_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
	);

`ifndef SYNTHESIS
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= imhpq_pkg::ST_DUP)
		else $error("bad status");
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != imhpq_pkg::ST_MIN |-> m_axis_tdata[44:3] == '0)
		else $error("nonzero fields");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("response dropped");
`endif
endmodule
`default_nettype wire

>>> tb/tb.sv
// testbench for the indexed min-heap priority queue: stream driver, monitor and heap predictor
`timescale 1ns / 1ps
module tb;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [imhpq_pkg::KEY_W-1:0] key;
		logic [imhpq_pkg::HANDLE_W-1:0] handle;
	} heap_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic signed [imhpq_pkg::KEY_W-1:0] min_key;
		logic [imhpq_pkg::HANDLE_W-1:0] min_handle;
	} heap_rsp_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata; // key, handle
	logic [1:0] s_axis_tuser; // req_type
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata; // status, min_key, min_handle

	indexed_min_heap_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// heap model state
	logic signed [imhpq_pkg::KEY_W-1:0] mdl_keys[imhpq_pkg::CAPACITY];
	logic [imhpq_pkg::HANDLE_W-1:0] mdl_handles[imhpq_pkg::CAPACITY];
	logic [imhpq_pkg::HANDLE_W-1:0] mdl_slot_of[imhpq_pkg::HANDLE_COUNT];
	bit mdl_queued[imhpq_pkg::HANDLE_COUNT];
	int unsigned mdl_count;

	heap_req_t pending_reqs[$];
	heap_rsp_t expected_rsps[$];
	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int idle_cycles;
	bit timed_out;
	bit hold_sender;

	// sender state seen at the last rising edge
	logic s_axis_tready_q;

	task automatic heap_swap(input int unsigned a, input int unsigned b);
		logic signed [imhpq_pkg::KEY_W-1:0] tk;
		logic [imhpq_pkg::HANDLE_W-1:0] th;
		tk = mdl_keys[a];
		th = mdl_handles[a];
		mdl_keys[a] = mdl_keys[b];
		mdl_handles[a] = mdl_handles[b];
		mdl_keys[b] = tk;
		mdl_handles[b] = th;
		mdl_slot_of[mdl_handles[a]] = imhpq_pkg::CAP_W'(a);
		mdl_slot_of[mdl_handles[b]] = imhpq_pkg::CAP_W'(b);
	endtask

	task automatic heap_sift_up(input int unsigned i);
		int unsigned p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (mdl_keys[i] < mdl_keys[p]) begin
				heap_swap(i, p);
				i = p;
			end else
				break;
		end
	endtask

	task automatic heap_sift_down();
		int unsigned i;
		int unsigned best;
		int unsigned l;
		i = 0;
		forever begin
			best = i;
			l = 2 * i + 1;
			if (l < mdl_count && mdl_keys[l] < mdl_keys[best])
				best = l;
			if (l + 1 < mdl_count && mdl_keys[l + 1] < mdl_keys[best])
				best = l + 1;
			if (best == i)
				break;
			heap_swap(i, best);
			i = best;
		end
	endtask

	task automatic predict_heap_op(input heap_req_t r);
		heap_rsp_t e;
		int unsigned s;
		e = '0;
		e.status = imhpq_pkg::ST_ACCEPTED;
		case (r.req_type)
			imhpq_pkg::REQ_PUSH: begin
				if (mdl_queued[r.handle])
					e.status = imhpq_pkg::ST_DUP;
				else if (mdl_count >= imhpq_pkg::CAPACITY)
					e.status = imhpq_pkg::ST_FULL;
				else begin
					s = mdl_count;
					mdl_keys[s] = r.key;
					mdl_handles[s] = r.handle;
					mdl_slot_of[r.handle] = imhpq_pkg::CAP_W'(s);
					mdl_queued[r.handle] = 1'b1;
					mdl_count = s + 1;
					heap_sift_up(s);
				end
			end
			imhpq_pkg::REQ_EXTRACT: begin
				if (mdl_count == 0)
					e.status = imhpq_pkg::ST_EMPTY;
				else begin
					e.status = imhpq_pkg::ST_MIN;
					e.min_key = mdl_keys[0];
					e.min_handle = mdl_handles[0];
					mdl_queued[mdl_handles[0]] = 1'b0;
					mdl_count = mdl_count - 1;
					mdl_keys[0] = mdl_keys[mdl_count];
					mdl_handles[0] = mdl_handles[mdl_count];
					mdl_slot_of[mdl_handles[0]] = '0;
					heap_sift_down();
				end
			end
			imhpq_pkg::REQ_DECREASE: begin
				if (!mdl_queued[r.handle])
					e.status = imhpq_pkg::ST_REJECT;
				else begin
					s = mdl_slot_of[r.handle];
					if (s >= mdl_count || !(r.key < mdl_keys[s]))
						e.status = imhpq_pkg::ST_REJECT;
					else begin
						mdl_keys[s] = r.key;
						heap_sift_up(s);
					end
				end
			end
			default: ;
		endcase
		expected_rsps.push_back(e);
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (!s_axis_tvalid || s_axis_tready_q) begin
				if (pending_reqs.size() > 0 && !hold_sender
						&& $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'd0, pending_reqs[0].handle, pending_reqs[0].key};
					s_axis_tuser <= pending_reqs[0].req_type;
					void'(pending_reqs.pop_front());
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		heap_req_t r;
		heap_rsp_t got;
		heap_rsp_t e;
		if (!arst_n) begin
			s_axis_tready_q <= 1'b0;
			idle_cycles <= 0;
		end else begin
			s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				r.req_type = s_axis_tuser;
				r.key = s_axis_tdata[31:0];
				r.handle = s_axis_tdata[41:32];
				predict_heap_op(r);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tdata[2:0];
				got.min_key = m_axis_tdata[34:3];
				got.min_handle = m_axis_tdata[44:35];
				if (expected_rsps.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected response %h", got);
				end else begin
					e = expected_rsps.pop_front();
					if (got !== e) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: status %0d/%0d key %0d/%0d handle %0d/%0d",
								e.status, got.status, e.min_key, got.min_key,
								e.min_handle, got.min_handle);
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (!s_axis_tvalid && expected_rsps.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic heap_req_t make_req(input logic [1:0] t, input logic signed [31:0] k,
			input logic [9:0] h);
		heap_req_t r;
		r.req_type = t;
		r.key = k;
		r.handle = h;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_key();
		case ($urandom_range(3))
			0: return $signed(32'($urandom_range(20)) - 10);
			1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom());
		endcase
	endfunction

	// fill a phase of requests: mostly pushes and extracts, push and decrease handles drawn from 0 to pool
	task automatic add_random(input int n, input int pool);
		int t;
		repeat (n) begin
			t = $urandom_range(99);
			if (t < 40)
				pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, rand_key(),
					10'($urandom_range(pool))));
			else if (t < 75)
				pending_reqs.push_back(make_req(imhpq_pkg::REQ_EXTRACT, rand_key(),
					10'($urandom())));
			else if (t < 97)
				pending_reqs.push_back(make_req(imhpq_pkg::REQ_DECREASE, rand_key(),
					10'($urandom_range(pool))));
			else
				pending_reqs.push_back(make_req(REQ_UNUSED, rand_key(), 10'($urandom())));
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		mismatches = 0;
		timed_out = 1'b0;
		hold_sender = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mdl_count = 0;
		for (int i = 0; i < imhpq_pkg::HANDLE_COUNT; i++)
			mdl_queued[i] = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty extract, extremes, duplicates, rejects, ties
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_EXTRACT, 0, 0));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_DECREASE, -5, 3));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, 32'sh7fffffff, 10'h3ff));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, 32'sh80000000, 10'h000));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, 7, 10'h3ff));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, 5, 10'h155));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, 5, 10'h2aa));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_DECREASE, 5, 10'h155));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_DECREASE, 32'sh80000000, 10'h3ff));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_DECREASE, 1, 10'h001));
		pending_reqs.push_back(make_req(REQ_UNUSED, -1, 10'h3ff));
		repeat (6)
			pending_reqs.push_back(make_req(imhpq_pkg::REQ_EXTRACT, -1, 10'h3ff));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, 1, 10'h3ff));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_EXTRACT, 0, 0));
		wait_drained();

		// fill to capacity, then one more push on handle 0, which is already queued
		for (int i = 0; i < imhpq_pkg::CAPACITY; i++)
			pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, rand_key(), 10'(i)));
		pending_reqs.push_back(make_req(imhpq_pkg::REQ_PUSH, 0, 0));
		hold_sender = 1'b0;
		wait_drained();
		// pause until everything is back, then empty it partly
		add_random(300, 1023);
		wait_drained();

		send_idle_pct = 76;
		add_random(150, 15);
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 76;
		add_random(150, 31);
		wait_drained();
		send_idle_pct = 22;
		recv_stall_pct = 22;
		add_random(200, 63);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule

>>> files.f
sv/imhpq_pkg.sv
sv/imhpq_front.sv
sv/imhpq_back.sv
sv/indexed_min_heap_priority_queue.sv
tb/tb.sv
